### design/point_rotate_about_pivot_unit_assert.svh
// Assertion macros used by the point rotation design.
`ifndef POINT_ROTATE_ABOUT_PIVOT_UNIT_ASSERT_SVH
`define POINT_ROTATE_ABOUT_PIVOT_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRAP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PRAP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/prap_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package prap_pkg;

    localparam int COORD_WIDTH  = 16;
    localparam int ANGLE_WIDTH  = 16;
    localparam int PHASE_WIDTH  = 32;
    localparam int CORDIC_STEPS = 18;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int CORDIC_W     = PHASE_WIDTH + 2;
    localparam int CORDIC_FRAC  = 30;
    localparam int FRAC_W       = 15;
    localparam int TRIG_SHIFT   = CORDIC_FRAC - FRAC_W;
    localparam int TRIG_W       = FRAC_W + 2;
    localparam int DIFF_W       = COORD_WIDTH + 1;
    localparam int PROD_W       = DIFF_W + TRIG_W;
    localparam int SUM_W        = PROD_W + 1;
    localparam int RND_W        = SUM_W - FRAC_W;
    localparam int RES_W        = RND_W + 1;
    localparam int CFG_DATA_W   = (COORD_WIDTH > ANGLE_WIDTH) ? COORD_WIDTH : ANGLE_WIDTH;
    localparam int CFG_IDX_W    = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_X = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_Y = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_DIR     = CFG_IDX_W'(3);

    localparam logic [PHASE_WIDTH-1:0] PHASE_QUARTER = {2'b01, {(PHASE_WIDTH-2){1'b0}}};
    localparam logic [PHASE_WIDTH-1:0] PHASE_HALF    = {1'b1, {(PHASE_WIDTH-1){1'b0}}};

    // Gain-corrected 1.0 in Q30.
    localparam logic signed [CORDIC_W-1:0] CORDIC_X0   = CORDIC_W'(652032874);
    localparam logic signed [CORDIC_W-1:0] CORDIC_HALF = CORDIC_W'(1) << (TRIG_SHIFT - 1);
    localparam logic signed [SUM_W-1:0]    SUM_HALF    = SUM_W'(1) << (FRAC_W - 1);

    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic                     busy;
        logic signed [TRIG_W-1:0] cos_q15;
        logic signed [TRIG_W-1:0] sin_q15;
    } trig_t;

    // Arctangent of 2^-idx as a fraction of a full turn, 2^32 per turn.
    function automatic logic signed [CORDIC_W-1:0] atan_turn(input logic [STEP_W-1:0] idx);
        logic signed [CORDIC_W-1:0] val;
        unique case (idx)
            STEP_W'(0):  val = CORDIC_W'(536870912);
            STEP_W'(1):  val = CORDIC_W'(316933406);
            STEP_W'(2):  val = CORDIC_W'(167458907);
            STEP_W'(3):  val = CORDIC_W'(85004756);
            STEP_W'(4):  val = CORDIC_W'(42667331);
            STEP_W'(5):  val = CORDIC_W'(21354465);
            STEP_W'(6):  val = CORDIC_W'(10679838);
            STEP_W'(7):  val = CORDIC_W'(5340245);
            STEP_W'(8):  val = CORDIC_W'(2670163);
            STEP_W'(9):  val = CORDIC_W'(1335087);
            STEP_W'(10): val = CORDIC_W'(667544);
            STEP_W'(11): val = CORDIC_W'(333772);
            STEP_W'(12): val = CORDIC_W'(166886);
            STEP_W'(13): val = CORDIC_W'(83443);
            STEP_W'(14): val = CORDIC_W'(41722);
            STEP_W'(15): val = CORDIC_W'(20861);
            STEP_W'(16): val = CORDIC_W'(10430);
            STEP_W'(17): val = CORDIC_W'(5215);
            default:     val = '0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

### design/prap_sincos.sv
`timescale 1ns / 1ps
`default_nettype none

module prap_sincos
    import prap_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [ANGLE_WIDTH-1:0] rotation_angle,
    input  wire logic                   anticlockwise,
    output trig_t                       trig
);

    typedef enum logic [1:0] {
        S_LOAD,
        S_ITER,
        S_FINISH,
        S_IDLE
    } state_t;

    state_t                      state_reg, state_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    logic signed [CORDIC_W-1:0]  x_reg, x_next;
    logic signed [CORDIC_W-1:0]  y_reg, y_next;
    logic signed [CORDIC_W-1:0]  z_reg, z_next;
    logic                        negate_reg, negate_next;
    logic signed [TRIG_W-1:0]    cos_reg, cos_next;
    logic signed [TRIG_W-1:0]    sin_reg, sin_next;

    logic [PHASE_WIDTH-1:0]      phase_raw;
    logic [PHASE_WIDTH-1:0]      phase_dir;
    logic [PHASE_WIDTH-1:0]      phase_shift;
    logic [PHASE_WIDTH-1:0]      phase_fold;
    logic                        fold;
    logic signed [CORDIC_W-1:0]  x_shift;
    logic signed [CORDIC_W-1:0]  y_shift;
    logic signed [CORDIC_W-1:0]  atan_val;
    logic signed [CORDIC_W-1:0]  x_rnd;
    logic signed [CORDIC_W-1:0]  y_rnd;
    logic signed [TRIG_W-1:0]    cos_raw;
    logic signed [TRIG_W-1:0]    sin_raw;

    always_comb
    begin
        phase_raw   = {rotation_angle, {(PHASE_WIDTH-ANGLE_WIDTH){1'b0}}};
        phase_dir   = anticlockwise ? phase_raw : (PHASE_WIDTH'(0) - phase_raw);
        phase_shift = phase_dir + PHASE_QUARTER;
        fold        = phase_shift[PHASE_WIDTH-1];
        phase_fold  = fold ? (phase_dir ^ PHASE_HALF) : phase_dir;

        x_shift  = x_reg >>> step_reg;
        y_shift  = y_reg >>> step_reg;
        atan_val = atan_turn(step_reg);

        x_rnd   = x_reg + CORDIC_HALF;
        y_rnd   = y_reg + CORDIC_HALF;
        cos_raw = $signed(x_rnd[TRIG_SHIFT+TRIG_W-1:TRIG_SHIFT]);
        sin_raw = $signed(y_rnd[TRIG_SHIFT+TRIG_W-1:TRIG_SHIFT]);

        state_next  = state_reg;
        step_next   = step_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        z_next      = z_reg;
        negate_next = negate_reg;
        cos_next    = cos_reg;
        sin_next    = sin_reg;

        if (start)
        begin
            state_next = S_LOAD;
        end
        else
        begin
            unique case (state_reg)
                S_LOAD:
                begin
                    x_next      = CORDIC_X0;
                    y_next      = '0;
                    z_next      = $signed({{(CORDIC_W-PHASE_WIDTH){phase_fold[PHASE_WIDTH-1]}},
                                           phase_fold});
                    negate_next = fold;
                    step_next   = '0;
                    state_next  = S_ITER;
                end
                S_ITER:
                begin
                    if (z_reg[CORDIC_W-1])
                    begin
                        x_next = x_reg + y_shift;
                        y_next = y_reg - x_shift;
                        z_next = z_reg + atan_val;
                    end
                    else
                    begin
                        x_next = x_reg - y_shift;
                        y_next = y_reg + x_shift;
                        z_next = z_reg - atan_val;
                    end
                    step_next = step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                    begin
                        state_next = S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    cos_next   = negate_reg ? (TRIG_W'(0) - cos_raw) : cos_raw;
                    sin_next   = negate_reg ? (TRIG_W'(0) - sin_raw) : sin_raw;
                    state_next = S_IDLE;
                end
                S_IDLE:
                begin
                end
                default:
                begin
                    state_next = S_LOAD;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            step_reg   <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
            z_reg      <= '0;
            negate_reg <= 1'b0;
            cos_reg    <= '0;
            sin_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            z_reg      <= z_next;
            negate_reg <= negate_next;
            cos_reg    <= cos_next;
            sin_reg    <= sin_next;
        end
    end

    assign trig.busy    = (state_reg != S_IDLE);
    assign trig.cos_q15 = cos_reg;
    assign trig.sin_q15 = sin_reg;

endmodule

`default_nettype wire

### design/prap_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module prap_datapath
    import prap_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [COORD_WIDTH-1:0] point_x,
    input  wire logic signed [COORD_WIDTH-1:0] point_y,
    input  wire logic signed [COORD_WIDTH-1:0] pivot_x,
    input  wire logic signed [COORD_WIDTH-1:0] pivot_y,
    input  wire trig_t                         trig,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0]      rotated_x,
    output logic signed [COORD_WIDTH-1:0]      rotated_y,
    output logic                               saturated
);

    logic                          va_reg, vb_reg, vc_reg;
    logic                          ready_a, ready_b, ready_c;

    logic signed [DIFF_W-1:0]      dx_reg, dx_next;
    logic signed [DIFF_W-1:0]      dy_reg, dy_next;
    logic signed [PROD_W-1:0]      p_xc_reg, p_xc_next;
    logic signed [PROD_W-1:0]      p_ys_reg, p_ys_next;
    logic signed [PROD_W-1:0]      p_xs_reg, p_xs_next;
    logic signed [PROD_W-1:0]      p_yc_reg, p_yc_next;
    logic signed [COORD_WIDTH-1:0] rx_reg, rx_next;
    logic signed [COORD_WIDTH-1:0] ry_reg, ry_next;
    logic                          sat_reg, sat_next;

    logic signed [PROD_W-1:0]      dx_ext, dy_ext, c_ext, s_ext;
    logic signed [SUM_W-1:0]       sum_x, sum_y, rsum_x, rsum_y;
    logic signed [RES_W-1:0]       res_x, res_y;
    logic                          clip_x, clip_y;

    function automatic logic signed [COORD_WIDTH-1:0] clip_coord(
        input logic signed [RES_W-1:0] val,
        output logic                   clipped
    );
        logic signed [RES_W-1:0] hi;
        logic signed [RES_W-1:0] lo;
        logic signed [COORD_WIDTH-1:0] res;
        hi = $signed({{(RES_W-COORD_WIDTH){COORD_MAX[COORD_WIDTH-1]}}, COORD_MAX});
        lo = $signed({{(RES_W-COORD_WIDTH){COORD_MIN[COORD_WIDTH-1]}}, COORD_MIN});
        clipped = 1'b1;
        if (val > hi)
        begin
            res = COORD_MAX;
        end
        else if (val < lo)
        begin
            res = COORD_MIN;
        end
        else
        begin
            res     = val[COORD_WIDTH-1:0];
            clipped = 1'b0;
        end
        return res;
    endfunction

    assign ready_c  = !vc_reg || out_ready;
    assign ready_b  = !vb_reg || ready_c;
    assign ready_a  = !va_reg || ready_b;
    assign in_ready = ready_a;

    always_comb
    begin
        dx_next = $signed({point_x[COORD_WIDTH-1], point_x}) -
                  $signed({pivot_x[COORD_WIDTH-1], pivot_x});
        dy_next = $signed({point_y[COORD_WIDTH-1], point_y}) -
                  $signed({pivot_y[COORD_WIDTH-1], pivot_y});

        dx_ext = $signed({{(PROD_W-DIFF_W){dx_reg[DIFF_W-1]}}, dx_reg});
        dy_ext = $signed({{(PROD_W-DIFF_W){dy_reg[DIFF_W-1]}}, dy_reg});
        c_ext  = $signed({{(PROD_W-TRIG_W){trig.cos_q15[TRIG_W-1]}}, trig.cos_q15});
        s_ext  = $signed({{(PROD_W-TRIG_W){trig.sin_q15[TRIG_W-1]}}, trig.sin_q15});

        p_xc_next = dx_ext * c_ext;
        p_ys_next = dy_ext * s_ext;
        p_xs_next = dx_ext * s_ext;
        p_yc_next = dy_ext * c_ext;

        sum_x  = $signed({p_xc_reg[PROD_W-1], p_xc_reg}) -
                 $signed({p_ys_reg[PROD_W-1], p_ys_reg});
        sum_y  = $signed({p_xs_reg[PROD_W-1], p_xs_reg}) +
                 $signed({p_yc_reg[PROD_W-1], p_yc_reg});
        rsum_x = sum_x + SUM_HALF;
        rsum_y = sum_y + SUM_HALF;

        res_x = $signed({{(RES_W-COORD_WIDTH){pivot_x[COORD_WIDTH-1]}}, pivot_x}) +
                $signed({rsum_x[SUM_W-1], rsum_x[SUM_W-1:FRAC_W]});
        res_y = $signed({{(RES_W-COORD_WIDTH){pivot_y[COORD_WIDTH-1]}}, pivot_y}) +
                $signed({rsum_y[SUM_W-1], rsum_y[SUM_W-1:FRAC_W]});

        rx_next  = clip_coord(res_x, clip_x);
        ry_next  = clip_coord(res_y, clip_y);
        sat_next = clip_x || clip_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
            begin
                va_reg <= in_valid;
            end
            if (ready_b)
            begin
                vb_reg <= va_reg;
            end
            if (ready_c)
            begin
                vc_reg <= vb_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && ready_a)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
        if (va_reg && ready_b)
        begin
            p_xc_reg <= p_xc_next;
            p_ys_reg <= p_ys_next;
            p_xs_reg <= p_xs_next;
            p_yc_reg <= p_yc_next;
        end
        if (vb_reg && ready_c)
        begin
            rx_reg  <= rx_next;
            ry_reg  <= ry_next;
            sat_reg <= sat_next;
        end
    end

    assign out_valid = vc_reg;
    assign rotated_x = rx_reg;
    assign rotated_y = ry_reg;
    assign saturated = sat_reg;

endmodule

`default_nettype wire

### design/point_rotate_about_pivot_unit.sv
// An accepted input word passes through the difference, product and result registers to m_axis.
// Throughput: one word per cycle while the CORDIC is idle; the three-stage pipeline stalls only on output backpressure.
// Sine and cosine come from an 18-step iterative CORDIC that runs once per angle or direction setting.
// After reset, and after each write to the angle or direction register, s_axis_tready
// stays low while the CORDIC reloads. Registers reset asynchronously, except the datapath data registers.
`timescale 1ns / 1ps
`default_nettype none
`include "point_rotate_about_pivot_unit_assert.svh"

module point_rotate_about_pivot_unit
    import prap_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [2*COORD_WIDTH-1:0]     s_axis_tdata,   // point_x, point_y
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic [2*COORD_WIDTH-1:0]          m_axis_tdata,   // rotated_x, rotated_y
    output logic                              m_axis_tuser,   // saturated
    input  wire logic                         cfg_we,
    input  wire logic [CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [CFG_DATA_W-1:0]        cfg_data
);

    logic [ANGLE_WIDTH-1:0]        angle_reg;
    logic signed [COORD_WIDTH-1:0] pivot_x_reg;
    logic signed [COORD_WIDTH-1:0] pivot_y_reg;
    logic                          dir_reg;

    logic                          start;
    trig_t                         trig;
    logic                          dp_in_ready;
    logic signed [COORD_WIDTH-1:0] rotated_x;
    logic signed [COORD_WIDTH-1:0] rotated_y;
    logic                          saturated;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg   <= '0;
            pivot_x_reg <= '0;
            pivot_y_reg <= '0;
            dir_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ANGLE:   angle_reg   <= cfg_data[ANGLE_WIDTH-1:0];
                CFG_PIVOT_X: pivot_x_reg <= $signed(cfg_data[COORD_WIDTH-1:0]);
                CFG_PIVOT_Y: pivot_y_reg <= $signed(cfg_data[COORD_WIDTH-1:0]);
                CFG_DIR:     dir_reg     <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign start = cfg_we && ((cfg_index == CFG_ANGLE) || (cfg_index == CFG_DIR));

    prap_sincos u_sincos (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .rotation_angle (angle_reg),
        .anticlockwise  (dir_reg),
        .trig           (trig)
    );

    prap_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid && !trig.busy),
        .in_ready  (dp_in_ready),
        .point_x   ($signed(s_axis_tdata[COORD_WIDTH-1:0])),
        .point_y   ($signed(s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH])),
        .pivot_x   (pivot_x_reg),
        .pivot_y   (pivot_y_reg),
        .trig      (trig),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .rotated_x (rotated_x),
        .rotated_y (rotated_y),
        .saturated (saturated)
    );

    assign s_axis_tready = dp_in_ready && !trig.busy;
    assign m_axis_tdata  = {rotated_y, rotated_x};
    assign m_axis_tuser  = saturated;

    // An angle write must hold off input while the CORDIC reloads.
    `PRAP_ASSERT_NEXT(a_angle_write_stalls, clk, rst_n, cfg_we && (cfg_index == CFG_ANGLE), !s_axis_tready, "input accepted right after an angle write")

    // A pivot_x write must not restart the sine and cosine calculation.
    `PRAP_ASSERT_NEXT(a_pivot_no_restart, clk, rst_n, cfg_we && (cfg_index == CFG_PIVOT_X) && !trig.busy, !trig.busy, "pivot write restarted the CORDIC")

    // A saturated word must carry at least one coordinate at a range limit.
    `PRAP_ASSERT_SAME(a_sat_at_limit, clk, rst_n, m_axis_tvalid && m_axis_tuser, (rotated_x == COORD_MAX) || (rotated_x == COORD_MIN) || (rotated_y == COORD_MAX) || (rotated_y == COORD_MIN), "saturated flag without a clipped coordinate")

endmodule

`default_nettype wire

### test/tb_point_rotate_about_pivot_unit.sv
`timescale 1ns / 1ps

module tb_point_rotate_about_pivot_unit;
    import prap_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] rx;
        logic [COORD_WIDTH-1:0] ry;
        logic                   sat;
    } rotated_point_t;

    class rotation_scoreboard;
        logic [ANGLE_WIDTH-1:0]        angle;
        logic signed [COORD_WIDTH-1:0] pvx;
        logic signed [COORD_WIDTH-1:0] pvy;
        logic                          ccw;
        rotated_point_t                pending_rotations[$];
        int                            mismatches;
        int                            words_seen;
        longint                        atan_step[CORDIC_STEPS] = '{
            536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
            10679838, 5340245, 2670163, 1335087, 667544, 333772,
            166886, 83443, 41722, 20861, 10430, 5215
        };

        function new();
            angle = '0;
            pvx = '0;
            pvy = '0;
            ccw = 1'b0;
            mismatches = 0;
            words_seen = 0;
        endfunction

        function int pending();
            return pending_rotations.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_ANGLE:   angle = val[ANGLE_WIDTH-1:0];
                CFG_PIVOT_X: pvx = val[COORD_WIDTH-1:0];
                CFG_PIVOT_Y: pvy = val[COORD_WIDTH-1:0];
                CFG_DIR:     ccw = val[0];
                default:     ;
            endcase
        endfunction

        // Rounded Q15 cosine and sine of a 32-bit phase.
        function void trig_q15(logic [PHASE_WIDTH-1:0] ph, output longint c, output longint s);
            longint x;
            longint y;
            longint z;
            longint nx;
            logic   flip;
            flip = 1'b0;
            if (((ph + PHASE_QUARTER) & PHASE_HALF) != '0)
            begin
                ph = ph - PHASE_HALF;
                flip = 1'b1;
            end
            z = longint'($signed(ph));
            x = 652032874;
            y = 0;
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                if (z >= 0)
                begin
                    nx = x - (y >>> i);
                    y = y + (x >>> i);
                    z = z - atan_step[i];
                end
                else
                begin
                    nx = x + (y >>> i);
                    y = y - (x >>> i);
                    z = z + atan_step[i];
                end
                x = nx;
            end
            c = (x + 16384) >>> 15;
            s = (y + 16384) >>> 15;
            if (flip)
            begin
                c = -c;
                s = -s;
            end
        endfunction

        function longint clip(longint v, inout logic sat);
            if (v > longint'(COORD_MAX))
            begin
                sat = 1'b1;
                return longint'(COORD_MAX);
            end
            if (v < longint'(COORD_MIN))
            begin
                sat = 1'b1;
                return longint'(COORD_MIN);
            end
            return v;
        endfunction

        function void note_point(logic [2*COORD_WIDTH-1:0] data);
            logic [PHASE_WIDTH-1:0] ph;
            longint                 c;
            longint                 s;
            longint                 dx;
            longint                 dy;
            longint                 nx;
            longint                 ny;
            rotated_point_t         e;
            ph = {angle, {(PHASE_WIDTH-ANGLE_WIDTH){1'b0}}};
            if (!ccw)
                ph = '0 - ph;
            trig_q15(ph, c, s);
            dx = longint'($signed(data[COORD_WIDTH-1:0])) - longint'(pvx);
            dy = longint'($signed(data[2*COORD_WIDTH-1:COORD_WIDTH])) - longint'(pvy);
            nx = longint'(pvx) + ((dx * c - dy * s + 16384) >>> 15);
            ny = longint'(pvy) + ((dx * s + dy * c + 16384) >>> 15);
            e.sat = 1'b0;
            nx = clip(nx, e.sat);
            ny = clip(ny, e.sat);
            e.rx = nx[COORD_WIDTH-1:0];
            e.ry = ny[COORD_WIDTH-1:0];
            pending_rotations.push_back(e);
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%s", msg);
        endfunction

        function void check_result(logic [2*COORD_WIDTH-1:0] data, logic sat);
            rotated_point_t e;
            words_seen++;
            if (pending_rotations.size() == 0)
            begin
                report($sformatf("word %0d: unexpected result %h / %b", words_seen, data, sat));
                return;
            end
            e = pending_rotations.pop_front();
            if (data[COORD_WIDTH-1:0] !== e.rx)
                report($sformatf("word %0d: rotated_x expected %0d got %0d", words_seen,
                    $signed(e.rx), $signed(data[COORD_WIDTH-1:0])));
            if (data[2*COORD_WIDTH-1:COORD_WIDTH] !== e.ry)
                report($sformatf("word %0d: rotated_y expected %0d got %0d", words_seen,
                    $signed(e.ry), $signed(data[2*COORD_WIDTH-1:COORD_WIDTH])));
            if (sat !== e.sat)
                report($sformatf("word %0d: saturated expected %b got %b", words_seen,
                    e.sat, sat));
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [2*COORD_WIDTH-1:0] s_axis_tdata;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [2*COORD_WIDTH-1:0] m_axis_tdata;
    logic                     m_axis_tuser;
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;

    rotation_scoreboard sb;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    int                 cycle_count;

    point_rotate_about_pivot_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Result side: random backpressure and checking of every accepted word.
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser);
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_point(input logic [COORD_WIDTH-1:0] x, input logic [COORD_WIDTH-1:0] y);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {y, x};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_point({y, x});
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task automatic set_config(input logic [3:0] which, input logic [CFG_DATA_W-1:0] ang,
                              input logic [CFG_DATA_W-1:0] px, input logic [CFG_DATA_W-1:0] py,
                              input logic [CFG_DATA_W-1:0] dirv);
        if (which[0])
            write_reg(CFG_ANGLE, ang);
        if (which[1])
            write_reg(CFG_PIVOT_X, px);
        if (which[2])
            write_reg(CFG_PIVOT_Y, py);
        if (which[3])
            write_reg(CFG_DIR, dirv);
        cfg_we <= 1'b0;
    endtask

    // Stop sending and let the pipeline empty.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    function automatic logic [COORD_WIDTH-1:0] pick_pivot();
        case ($urandom_range(5))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return '0;
            3:       return COORD_WIDTH'($urandom_range(64)) - COORD_WIDTH'(32);
            default: return COORD_WIDTH'($urandom);
        endcase
    endfunction

    function automatic logic [COORD_WIDTH-1:0] pick_coord(input logic [COORD_WIDTH-1:0] centre);
        case ($urandom_range(9))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2, 3:    return centre + COORD_WIDTH'($urandom_range(200)) - COORD_WIDTH'(100);
            default: return COORD_WIDTH'($urandom);
        endcase
    endfunction

    function automatic logic [ANGLE_WIDTH-1:0] pick_angle();
        case ($urandom_range(9))
            0:       return '0;
            1:       return ANGLE_WIDTH'(1);
            2:       return ANGLE_WIDTH'(16384);
            3:       return ANGLE_WIDTH'(32768);
            4:       return ANGLE_WIDTH'(49152);
            5:       return '1;
            6:       return ANGLE_WIDTH'(8192 * $urandom_range(7));
            default: return ANGLE_WIDTH'($urandom);
        endcase
    endfunction

    initial
    begin
        sb = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_ANGLE;
        cfg_data <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // With a zero angle every point must come back unchanged.
        send_point(16'h0000, 16'h0000);
        send_point(16'h7FFF, 16'h7FFF);
        send_point(16'h8000, 16'h8000);
        send_point(16'h7FFF, 16'h8000);
        send_point(16'h5555, 16'hAAAA);
        send_point(16'hFFFF, 16'h0001);

        // Quarter turn about a corner pivot drives rotated_y into saturation for three of these points.
        settle();
        set_config(4'b1111, 16'd16384, 16'h8000, 16'h7FFF, 16'h0001);
        send_point(16'h7FFF, 16'h8000);
        send_point(16'h8000, 16'h7FFF);
        send_point(16'h0000, 16'h0000);
        send_point(16'hAAAA, 16'h5555);

        // Half turn, clockwise: the phase is folded by a half turn.
        settle();
        set_config(4'b1111, 16'd32768, 16'h7FFF, 16'h8000, 16'h0000);
        send_point(16'h8000, 16'h7FFF);
        send_point(16'h7FFF, 16'h8000);
        send_point(16'h0001, 16'hFFFF);
        send_point(16'h1234, 16'hEDCB);

        // Bits above the direction bit are ignored, so this rotates clockwise.
        settle();
        set_config(4'b1111, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFE);
        send_point(16'h7FFF, 16'h7FFF);
        send_point(16'h8000, 16'h8000);
        send_point(16'h0100, 16'hFF00);
        send_point(16'h0000, 16'h7FFF);

        settle();
        set_config(4'b1001, 16'd49152, 16'h0000, 16'h0000, 16'hFFFF);
        send_point(16'h7FFF, 16'h0000);
        send_point(16'h8000, 16'h0000);
        send_point(16'h0000, 16'h8000);
        send_point(16'h4000, 16'hC000);

        for (int seg = 0; seg < 24; seg++)
        begin
            settle();
            set_config(4'($urandom_range(15)), pick_angle(), pick_pivot(), pick_pivot(),
                       CFG_DATA_W'($urandom));
            case (seg % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 61;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 61;
                end
                default:
                begin
                    send_idle_pct = 32;
                    recv_stall_pct = 32;
                end
            endcase
            repeat (56) send_point(pick_coord(sb.pvx), pick_coord(sb.pvy));
        end

        settle();
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
